### rtl/psc_pkg.sv
// shared widths, register indexes and correction codes for the pressure compensation core
package psc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_WORD_ONE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_WORD_TWO   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_WORD_THREE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_WORD_FOUR  = 8'd3;

    // number of register stages from input beat to output register
    localparam int NUM_STAGES = 8;

    // second-order correction branch
    typedef enum logic [1:0] {
        CORR_NONE = 2'd0,
        CORR_LOW  = 2'd1,
        CORR_HIGH = 2'd2
    } corr_t;

endpackage

### rtl/pressure_sensor_compensation_core.sv
// Eight-stage compensation pipeline: raw pressure and temperature to tenths of mbar and degC.
// Throughput: one beat per cycle while out_stall is low; each stage holds its valid bit and
// advances when the next stage is empty or moving, so bubbles collapse under output stall.
// Reset clears all stage valid bits and the four calibration words to zero.
module pressure_sensor_compensation_core
    import psc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [15:0]                  pressure_raw,
    input  logic [15:0]                  temp_raw,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [31:0]           temperature_tenths,
    output logic signed [31:0]           pressure_tenths
);

    // calibration words
    logic [15:0] cal1_reg, cal2_reg, cal3_reg, cal4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal1_reg <= '0;
            cal2_reg <= '0;
            cal3_reg <= '0;
            cal4_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CAL_WORD_ONE:   cal1_reg <= cfg_data;
                REG_CAL_WORD_TWO:   cal2_reg <= cfg_data;
                REG_CAL_WORD_THREE: cal3_reg <= cfg_data;
                REG_CAL_WORD_FOUR:  cal4_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // coefficient unpacking
    logic [14:0]        c1;
    logic [11:0]        c2;
    logic [9:0]         c3, c4;
    logic [10:0]        c5;
    logic [5:0]         c6;
    logic [16:0]        ut1;
    logic signed [7:0]  c6p50;
    logic signed [10:0] c4m;
    logic signed [10:0] c3s;
    logic [6:0]         c6p24;

    assign c1    = cal1_reg[15:1];
    assign c2    = {cal3_reg[5:0], cal4_reg[5:0]};
    assign c3    = cal4_reg[15:6];
    assign c4    = cal3_reg[15:6];
    assign c5    = {cal1_reg[0], cal2_reg[15:6]};
    assign c6    = cal2_reg[5:0];
    assign ut1   = {3'b000, c5, 3'b000} + 17'd20224;
    assign c6p50 = $signed({2'b00, c6}) + 8'sd50;
    assign c4m   = $signed({1'b0, c4}) - 11'sd512;
    assign c3s   = $signed({1'b0, c3});
    assign c6p24 = {1'b0, c6} + 7'd24;

    // stage valid bits and ready chain
    logic [NUM_STAGES:1]   v_reg, v_next;
    logic [NUM_STAGES+1:1] ready;

    always_comb
    begin
        ready[NUM_STAGES+1] = !out_stall;
        for (int k = NUM_STAGES; k >= 1; k--)
        begin
            ready[k] = !v_reg[k] || ready[k+1];
        end
        v_next[1] = ready[1] ? in_valid : v_reg[1];
        for (int k = 2; k <= NUM_STAGES; k++)
        begin
            v_next[k] = ready[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !ready[1];
    assign out_valid = v_reg[NUM_STAGES];

    // stage 1: temperature difference and pressure offset
    logic signed [17:0] dt_next, dt_s1_reg;
    logic signed [17:0] d1m_next, d1m_s1_reg;

    assign dt_next  = $signed({2'b00, temp_raw}) - $signed({1'b0, ut1});
    assign d1m_next = $signed({2'b00, pressure_raw}) - 18'sd7168;

    // stage 2: three coefficient products
    logic signed [25:0] tprod_next, tprod_s2_reg;
    logic signed [28:0] oprod_next, oprod_s2_reg;
    logic signed [28:0] sprod_next, sprod_s2_reg;
    logic signed [17:0] d1m_s2_reg;

    assign tprod_next = 26'(dt_s1_reg) * 26'(c6p50);
    assign oprod_next = 29'(dt_s1_reg) * 29'(c4m);
    assign sprod_next = 29'(dt_s1_reg) * 29'(c3s);

    // stage 3: first-order temperature, offset and sensitivity
    logic signed [15:0] temp_next, temp_s3_reg;
    logic signed [17:0] off_next, off_s3_reg;
    logic signed [19:0] sens_next, sens_s3_reg;
    logic signed [17:0] d1m_s3_reg;

    assign temp_next = $signed(tprod_s2_reg[25:10]) + 16'sd200;
    assign off_next  = $signed({4'b0000, c2, 2'b00}) + 18'($signed(oprod_s2_reg[28:12]));
    assign sens_next = $signed({5'b00000, c1}) + 20'($signed(sprod_s2_reg[28:10]))
                     + 20'sd24576;

    // stage 4: sensitivity product, branch pick and squared distance
    logic signed [37:0] mprod_next, mprod_s4_reg;
    logic signed [17:0] off_s4_reg;
    logic signed [15:0] temp_s4_reg;
    logic signed [15:0] dval;
    logic signed [31:0] dsq_next, dsq_s4_reg;
    corr_t              corr_next, corr_s4_reg;

    assign mprod_next = 38'(sens_s3_reg) * 38'(d1m_s3_reg);

    always_comb
    begin
        if (temp_s3_reg < 16'sd200)
        begin
            corr_next = CORR_LOW;
        end
        else if (temp_s3_reg > 16'sd450)
        begin
            corr_next = CORR_HIGH;
        end
        else
        begin
            corr_next = CORR_NONE;
        end
        dval = (corr_next == CORR_LOW) ? (16'sd200 - temp_s3_reg) : (16'sd450 - temp_s3_reg);
    end

    assign dsq_next = 32'(dval) * 32'(dval);

    // stage 5: pressure before scaling and second-order temperature product
    logic signed [24:0] x_next, x_s5_reg;
    logic [9:0]         kc;
    logic [35:0]        t2prod_next, t2prod_s5_reg;
    logic signed [15:0] temp_s5_reg;
    corr_t              corr_s5_reg;

    assign x_next = 25'($signed(mprod_s4_reg[37:14])) - 25'(off_s4_reg);

    always_comb
    begin
        case (corr_s4_reg)
            CORR_LOW: kc = 10'({3'b000, c6p24} * 10'd11);
            default:  kc = 10'({3'b000, c6p24} * 10'd3);
        endcase
    end

    assign t2prod_next = 36'(kc) * 36'(dsq_s4_reg[25:0]);

    // stage 6: scaled pressure and temperature correction
    logic signed [28:0] x10;
    logic signed [24:0] p_next, p_s6_reg;
    logic [15:0]        t2_next, t2_s6_reg;
    logic signed [15:0] temp_s6_reg;
    corr_t              corr_s6_reg;

    assign x10     = 29'(x_s5_reg) * 29'sd10;
    assign p_next  = 25'($signed(x10[28:5])) + 25'sd2500;
    assign t2_next = (corr_s5_reg == CORR_NONE) ? 16'd0 : t2prod_s5_reg[35:20];

    // stage 7: corrected temperature and pressure correction product
    logic [17:0]        m1;
    logic signed [25:0] m2;
    logic signed [44:0] p2prod_next, p2prod_s7_reg;
    logic signed [17:0] tempf_next, tempf_s7_reg;
    logic signed [24:0] p_s7_reg;
    corr_t              corr_s7_reg;

    always_comb
    begin
        case (corr_s6_reg)
            CORR_LOW:
            begin
                m1 = {2'b00, t2_s6_reg} * 18'd3;
                m2 = 26'(p_s6_reg) - 26'sd3500;
            end
            default:
            begin
                m1 = {2'b00, t2_s6_reg};
                m2 = 26'(p_s6_reg) - 26'sd10000;
            end
        endcase
    end

    assign p2prod_next = 45'($signed({1'b0, m1})) * 45'(m2);
    assign tempf_next  = 18'(temp_s6_reg) - 18'($signed({1'b0, t2_s6_reg}));

    // stage 8: output register
    logic signed [31:0] p2;
    logic signed [31:0] temperature_tenths_reg, pressure_tenths_reg;

    always_comb
    begin
        case (corr_s7_reg)
            CORR_LOW:  p2 = 32'($signed(p2prod_s7_reg[44:14]));
            CORR_HIGH: p2 = $signed(p2prod_s7_reg[44:13]);
            default:   p2 = 32'sd0;
        endcase
    end

    // payload registers advance with their stage
    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            dt_s1_reg  <= dt_next;
            d1m_s1_reg <= d1m_next;
        end
        if (ready[2])
        begin
            tprod_s2_reg <= tprod_next;
            oprod_s2_reg <= oprod_next;
            sprod_s2_reg <= sprod_next;
            d1m_s2_reg   <= d1m_s1_reg;
        end
        if (ready[3])
        begin
            temp_s3_reg <= temp_next;
            off_s3_reg  <= off_next;
            sens_s3_reg <= sens_next;
            d1m_s3_reg  <= d1m_s2_reg;
        end
        if (ready[4])
        begin
            mprod_s4_reg <= mprod_next;
            off_s4_reg   <= off_s3_reg;
            temp_s4_reg  <= temp_s3_reg;
            dsq_s4_reg   <= dsq_next;
            corr_s4_reg  <= corr_next;
        end
        if (ready[5])
        begin
            x_s5_reg      <= x_next;
            t2prod_s5_reg <= t2prod_next;
            temp_s5_reg   <= temp_s4_reg;
            corr_s5_reg   <= corr_s4_reg;
        end
        if (ready[6])
        begin
            p_s6_reg    <= p_next;
            t2_s6_reg   <= t2_next;
            temp_s6_reg <= temp_s5_reg;
            corr_s6_reg <= corr_s5_reg;
        end
        if (ready[7])
        begin
            p2prod_s7_reg <= p2prod_next;
            tempf_s7_reg  <= tempf_next;
            p_s7_reg      <= p_s6_reg;
            corr_s7_reg   <= corr_s6_reg;
        end
        if (ready[8])
        begin
            temperature_tenths_reg <= 32'(tempf_s7_reg);
            pressure_tenths_reg    <= 32'(p_s7_reg) - p2;
        end
    end

    assign temperature_tenths = temperature_tenths_reg;
    assign pressure_tenths    = pressure_tenths_reg;

    // an accepted beat always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v_reg[1])
        else $error("accepted beat not captured in first stage");

    // an empty output register means the whole chain can move
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register empty");

    // without second-order correction the pressure passes through unchanged
    a_no_corr_pass: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[7] && ready[8] && corr_s7_reg == CORR_NONE
        |=> pressure_tenths == 32'($past(p_s7_reg)))
        else $error("pressure changed without a correction branch");

endmodule
